FILE: rtl/core/wulm_pkg.sv
// Shared types and constants for the windowed usage level monitor.
package wulm_pkg;

  // Default structural sizes
  localparam int LEVEL_BITS_DEF  = 8;
  localparam int TIME_BITS_DEF   = 48;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Fixed field widths
  localparam int CMD_BITS      = 2;
  localparam int REQ_BITS      = 8;
  localparam int OUT_TIME_BITS = 48;
  localparam int ACT_BITS      = 40;
  localparam int PCT_BITS      = 15;
  localparam int NLEV_BITS     = 9;
  localparam int WIN_BITS      = 32;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_IDX_BITS  = 1;

  // Percentage scaling: activity * 100 * 2^8 / (top * window)
  localparam int PCT_MUL       = 100;
  localparam int PCT_MUL_BITS  = 7;
  localparam int PCT_FRAC_BITS = 8;
  localparam int PCT_FULL      = 25600;
  localparam int PROD_BITS     = ACT_BITS + PCT_MUL_BITS;
  localparam int NUM_BITS      = PROD_BITS + PCT_FRAC_BITS;

  // Register reset values
  localparam int NUM_LEVELS_RESET = 2;
  localparam int WINDOW_RESET     = 1000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_NUM_LEVELS    = 1'b0,
    CFG_WINDOW_CYCLES = 1'b1
  } cfg_idx_t;

  // Input commands
  typedef enum logic [CMD_BITS-1:0] {
    CMD_TICK = 2'd0,
    CMD_INC  = 2'd1,
    CMD_DEC  = 2'd2,
    CMD_SET  = 2'd3
  } cmd_t;

  // Closed window record handed from front to back
  typedef struct packed {
    logic [OUT_TIME_BITS-1:0] end_time;
    logic [ACT_BITS-1:0]      activity;
  } win_rec_t;

  // Back end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MULT,
    BK_CHECK,
    BK_DIV,
    BK_HOLD
  } bk_state_t;

endpackage

FILE: rtl/core/wulm_front.sv
// Front end: applies level commands, accumulates ticks and closes windows.
module wulm_front #(
  parameter int LEVEL_BITS = wulm_pkg::LEVEL_BITS_DEF,
  parameter int TIME_BITS  = wulm_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic [wulm_pkg::CMD_BITS-1:0]   command,
  input  logic [wulm_pkg::REQ_BITS-1:0]   new_level,
  input  logic [LEVEL_BITS-1:0]           top,
  input  logic [wulm_pkg::WIN_BITS-1:0]   win,
  input  logic                            q_full,
  output logic                            q_push,
  output wulm_pkg::win_rec_t              q_rec
);

  localparam int RW = (LEVEL_BITS > wulm_pkg::REQ_BITS) ? LEVEL_BITS : wulm_pkg::REQ_BITS;
  localparam int AW = wulm_pkg::ACT_BITS;

  logic [LEVEL_BITS-1:0]             level, level_next;
  logic [AW-1:0]                     act, act_next;
  logic [wulm_pkg::WIN_BITS-1:0]     ticks, ticks_next;
  logic [TIME_BITS-1:0]              elapsed, elapsed_next;
  logic [TIME_BITS-1:0]              elapsed_inc;
  logic [AW:0]                       act_sum;
  logic                              accept;
  wulm_pkg::cmd_t                    cmd_code;

  assign accept      = push & ~q_full;
  assign cmd_code    = wulm_pkg::cmd_t'(command);
  assign act_sum     = {1'b0, act} + (AW+1)'(level);
  // tick counter wraps at its own width
  assign elapsed_inc = elapsed + TIME_BITS'(1);

  // Command decode and window accounting
  always_comb begin
    level_next   = level;
    act_next     = act;
    ticks_next   = ticks;
    elapsed_next = elapsed;
    q_push       = 1'b0;
    q_rec.end_time = wulm_pkg::OUT_TIME_BITS'(elapsed_inc);
    q_rec.activity = act_sum[AW] ? {AW{1'b1}} : act_sum[AW-1:0];
    if (accept) begin
      case (cmd_code)
        wulm_pkg::CMD_INC: begin
          if (level < top) level_next = level + LEVEL_BITS'(1);
        end
        wulm_pkg::CMD_DEC: begin
          if (level != '0) level_next = level - LEVEL_BITS'(1);
        end
        wulm_pkg::CMD_SET: begin
          level_next = (RW'(new_level) > RW'(top)) ? top : LEVEL_BITS'(new_level);
        end
        wulm_pkg::CMD_TICK: begin
          elapsed_next = elapsed_inc;
          act_next     = q_rec.activity;
          ticks_next   = ticks + wulm_pkg::WIN_BITS'(1);
          // window closes once its tick count reaches the window length
          if (ticks_next >= win) begin
            q_push     = 1'b1;
            act_next   = '0;
            ticks_next = '0;
          end
        end
        default: begin
          level_next = level;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      level   <= '0;
      act     <= '0;
      ticks   <= '0;
      elapsed <= '0;
    end else begin
      level   <= level_next;
      act     <= act_next;
      ticks   <= ticks_next;
      elapsed <= elapsed_next;
    end
  end

endmodule

FILE: rtl/core/wulm_queue.sv
// Short queue of closed window records between front and back.
module wulm_queue #(
  parameter int DEPTH = wulm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr,
  input  wulm_pkg::win_rec_t din,
  input  logic               rd,
  output wulm_pkg::win_rec_t dout,
  output logic               full,
  output logic               empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  wulm_pkg::win_rec_t slots [DEPTH];
  logic [PW-1:0]      wr_ptr, rd_ptr;
  logic [CW-1:0]      count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (wr) slots[wr_ptr] <= din;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (rd) rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (wr && !rd)      count <= count + CW'(1);
      else if (rd && !wr) count <= count - CW'(1);
    end
  end

endmodule

FILE: rtl/core/wulm_back.sv
// Back end: computes the usage percentage of a window and holds the result.
module wulm_back #(
  parameter int LEVEL_BITS = wulm_pkg::LEVEL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_empty,
  input  wulm_pkg::win_rec_t                  q_rec,
  output logic                                q_pop,
  input  logic [LEVEL_BITS-1:0]               top,
  input  logic [wulm_pkg::WIN_BITS-1:0]       win,
  input  logic                                pop,
  output logic                                empty,
  output logic [wulm_pkg::OUT_TIME_BITS-1:0]  window_end_time,
  output logic [wulm_pkg::ACT_BITS-1:0]       window_activity,
  output logic [wulm_pkg::PCT_BITS-1:0]       usage_percent
);

  localparam int DW  = LEVEL_BITS + wulm_pkg::WIN_BITS;
  localparam int CMW = (DW > wulm_pkg::ACT_BITS) ? DW : wulm_pkg::ACT_BITS;
  localparam int QB  = wulm_pkg::PCT_BITS;
  localparam int NB  = wulm_pkg::NUM_BITS;
  localparam int KB  = $clog2(QB);

  wulm_pkg::bk_state_t       state, state_next;
  wulm_pkg::win_rec_t        rec;
  logic [DW-1:0]             den;
  logic [wulm_pkg::PROD_BITS-1:0] prod;
  logic [NB-1:0]             num;
  logic [DW-1:0]             rem;
  logic [QB-1:0]             low_bits;
  logic [QB-1:0]             quo;
  logic [KB-1:0]             cnt;
  logic [DW:0]               rem_shift;
  logic                      rem_ge;
  logic                      out_valid;
  logic                      slot_free;
  logic                      load;

  assign num       = {prod, {wulm_pkg::PCT_FRAC_BITS{1'b0}}};
  assign rem_shift = {rem, low_bits[QB-1]};
  assign rem_ge    = (rem_shift >= (DW+1)'(den));
  assign slot_free = ~out_valid | pop;
  assign empty     = ~out_valid;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      wulm_pkg::BK_IDLE:  if (!q_empty) state_next = wulm_pkg::BK_MULT;
      wulm_pkg::BK_MULT:  state_next = wulm_pkg::BK_CHECK;
      wulm_pkg::BK_CHECK: begin
        if (den == '0 || CMW'(rec.activity) >= CMW'(den)) state_next = wulm_pkg::BK_HOLD;
        else                                              state_next = wulm_pkg::BK_DIV;
      end
      wulm_pkg::BK_DIV:   if (cnt == '0) state_next = wulm_pkg::BK_HOLD;
      wulm_pkg::BK_HOLD:  if (slot_free) state_next = wulm_pkg::BK_IDLE;
      default:            state_next = wulm_pkg::BK_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    q_pop = 1'b0;
    load  = 1'b0;
    case (state)
      wulm_pkg::BK_IDLE: q_pop = ~q_empty;
      wulm_pkg::BK_HOLD: load  = slot_free;
      default: begin
        q_pop = 1'b0;
        load  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= wulm_pkg::BK_IDLE;
    else     state <= state_next;
  end

  // Datapath: operands, saturation check, restoring divide
  always_ff @(posedge clk) begin
    case (state)
      wulm_pkg::BK_IDLE: begin
        rec <= q_rec;
      end
      wulm_pkg::BK_MULT: begin
        den  <= DW'(top) * DW'(win);
        prod <= wulm_pkg::PROD_BITS'(rec.activity)
                * wulm_pkg::PROD_BITS'(wulm_pkg::PCT_MUL);
      end
      wulm_pkg::BK_CHECK: begin
        // activity >= top*window means the quotient is at least full scale
        if (den == '0) quo <= '0;
        else           quo <= QB'(wulm_pkg::PCT_FULL);
        rem      <= DW'(num[NB-1:QB]);
        low_bits <= num[QB-1:0];
        cnt      <= KB'(QB - 1);
      end
      wulm_pkg::BK_DIV: begin
        rem      <= rem_ge ? DW'(rem_shift - (DW+1)'(den)) : DW'(rem_shift);
        quo      <= {quo[QB-2:0], rem_ge};
        low_bits <= {low_bits[QB-2:0], 1'b0};
        cnt      <= cnt - KB'(1);
      end
      default: begin
        rec <= rec;
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load) begin
      window_end_time <= rec.end_time;
      window_activity <= rec.activity;
      usage_percent   <= quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)       out_valid <= 1'b0;
    else if (load) out_valid <= 1'b1;
    else if (pop)  out_valid <= 1'b0;
  end

endmodule

FILE: rtl/core/windowed_usage_level_monitor.sv
// Top level of the windowed usage level monitor.
//
//  Channel   Direction  Handshake             Payload
//  input     in         push / full           command, new_level
//  result    out        empty / pop           window_end_time, window_activity, usage_percent
//  config    in         cfg_write             cfg_index, cfg_data
//
// Commands are applied as they are accepted, while full is low. A window-closing tick queues a record;
// the back end takes each record through a multiply state, a check state and
// 15 restoring-divide steps (divide skipped on saturation), one record at a time.
// full rises while the record queue holds QUEUE_DEPTH entries.
// A finished result sits in the output register until popped; the back end
// keeps working on the next record meanwhile. Synchronous reset, no clearing pass.
module windowed_usage_level_monitor #(
  parameter int LEVEL_BITS  = wulm_pkg::LEVEL_BITS_DEF,
  parameter int TIME_BITS   = wulm_pkg::TIME_BITS_DEF,
  parameter int QUEUE_DEPTH = wulm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [wulm_pkg::CMD_BITS-1:0]       command,
  input  logic [wulm_pkg::REQ_BITS-1:0]       new_level,
  output logic                                empty,
  input  logic                                pop,
  output logic [wulm_pkg::OUT_TIME_BITS-1:0]  window_end_time,
  output logic [wulm_pkg::ACT_BITS-1:0]       window_activity,
  output logic [wulm_pkg::PCT_BITS-1:0]       usage_percent,
  input  logic                                cfg_write,
  input  logic [wulm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [wulm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int TW = LEVEL_BITS + wulm_pkg::NLEV_BITS;

  logic [wulm_pkg::NLEV_BITS-1:0] num_levels;
  logic [wulm_pkg::WIN_BITS-1:0]  window_cycles;
  logic [TW-1:0]                  top_raw;
  logic [TW-1:0]                  level_cap;
  logic [LEVEL_BITS-1:0]          top;
  logic [wulm_pkg::WIN_BITS-1:0]  win;
  logic                           q_push, q_pop, q_full, q_empty;
  wulm_pkg::win_rec_t             q_in, q_out;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_levels    <= wulm_pkg::NLEV_BITS'(wulm_pkg::NUM_LEVELS_RESET);
      window_cycles <= wulm_pkg::WIN_BITS'(wulm_pkg::WINDOW_RESET);
    end else if (cfg_write) begin
      case (wulm_pkg::cfg_idx_t'(cfg_index))
        wulm_pkg::CFG_NUM_LEVELS:    num_levels    <= cfg_data[wulm_pkg::NLEV_BITS-1:0];
        wulm_pkg::CFG_WINDOW_CYCLES: window_cycles <= cfg_data[wulm_pkg::WIN_BITS-1:0];
        default:                     num_levels    <= num_levels;
      endcase
    end
  end

  // Effective top level and window length
  assign top_raw   = (num_levels == '0) ? '0 : TW'(num_levels) - TW'(1);
  assign level_cap = TW'({LEVEL_BITS{1'b1}});
  assign top       = (top_raw > level_cap) ? LEVEL_BITS'(level_cap) : LEVEL_BITS'(top_raw);
  assign win       = (window_cycles == '0) ? wulm_pkg::WIN_BITS'(1) : window_cycles;

  assign full = q_full;

  wulm_front #(
    .LEVEL_BITS (LEVEL_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .command   (command),
    .new_level (new_level),
    .top       (top),
    .win       (win),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_rec     (q_in)
  );

  wulm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .din   (q_in),
    .rd    (q_pop),
    .dout  (q_out),
    .full  (q_full),
    .empty (q_empty)
  );

  wulm_back #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_rec           (q_out),
    .q_pop           (q_pop),
    .top             (top),
    .win             (win),
    .pop             (pop),
    .empty           (empty),
    .window_end_time (window_end_time),
    .window_activity (window_activity),
    .usage_percent   (usage_percent)
  );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the windowed usage level monitor.
module tb_top;
  import wulm_pkg::*;

  localparam int LEVEL_MAX    = (1 << LEVEL_BITS_DEF) - 1;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE_WAIT  = 40;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 121;

  // One finished window as the block should report it
  typedef struct packed {
    logic [OUT_TIME_BITS-1:0] end_time;
    logic [ACT_BITS-1:0]      activity;
    logic [PCT_BITS-1:0]      percent;
  } window_result_t;

  // Tracks level and window sums, queues the windows that must come out
  class window_scoreboard;
    logic [NLEV_BITS-1:0]      num_levels;
    logic [WIN_BITS-1:0]       window_cycles;
    logic [LEVEL_BITS_DEF-1:0] level;
    logic [ACT_BITS-1:0]       activity;
    logic [WIN_BITS-1:0]       window_ticks;
    logic [TIME_BITS_DEF-1:0]  tick_count;
    window_result_t            pending_windows[$];
    int unsigned               mismatches;

    function new();
      num_levels    = NUM_LEVELS_RESET;
      window_cycles = WINDOW_RESET;
      level         = '0;
      activity      = '0;
      window_ticks  = '0;
      tick_count    = '0;
      mismatches    = 0;
    endfunction

    function void set_register(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_NUM_LEVELS:    num_levels = data[NLEV_BITS-1:0];
        CFG_WINDOW_CYCLES: window_cycles = data[WIN_BITS-1:0];
        default: ;
      endcase
    endfunction

    // Zero or one level means top 0; the top is capped at the level width
    function logic [LEVEL_BITS_DEF-1:0] top_level();
      logic [NLEV_BITS-1:0] t;
      t = (num_levels == 0) ? '0 : num_levels - 1'b1;
      return (t > LEVEL_MAX) ? LEVEL_MAX[LEVEL_BITS_DEF-1:0] : t[LEVEL_BITS_DEF-1:0];
    endfunction

    // A zero window counts as one tick
    function longint unsigned window_len();
      return (window_cycles == 0) ? 64'd1 : 64'(window_cycles);
    endfunction

    function logic [PCT_BITS-1:0] percent_of(logic [ACT_BITS-1:0] act);
      longint unsigned den;
      longint unsigned p;
      den = 64'(top_level()) * window_len();
      if (den == 0) return '0;
      p = (64'(act) * 64'(PCT_MUL) * (64'd1 << PCT_FRAC_BITS)) / den;
      if (p > PCT_FULL) p = PCT_FULL;
      return p[PCT_BITS-1:0];
    endfunction

    // Apply one accepted command; a window-closing tick queues a result
    function void note_command(cmd_t c, logic [REQ_BITS-1:0] req);
      logic [LEVEL_BITS_DEF-1:0] top;
      logic [ACT_BITS:0]         sum;
      window_result_t            w;
      top = top_level();
      case (c)
        CMD_INC: if (level < top) level = level + 1'b1;
        CMD_DEC: if (level > 0) level = level - 1'b1;
        CMD_SET: level = (req > top) ? top : req;
        default: begin
          tick_count   = tick_count + 1'b1;
          sum          = activity + level;
          activity     = sum[ACT_BITS] ? '1 : sum[ACT_BITS-1:0];
          window_ticks = window_ticks + 1'b1;
          if (window_ticks >= window_len()) begin
            w.end_time = tick_count;
            w.activity = activity;
            w.percent  = percent_of(activity);
            pending_windows.insert(pending_windows.size(), w);
            activity     = '0;
            window_ticks = '0;
          end
        end
      endcase
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    // Compare one popped transaction with the oldest queued window
    task check_window(logic [OUT_TIME_BITS-1:0] t, logic [ACT_BITS-1:0] a,
                      logic [PCT_BITS-1:0] p);
      window_result_t w;
      if (pending_windows.size() == 0) begin
        report($sformatf("unexpected window end_time=%0d activity=%0d pct=%0d", t, a, p));
        return;
      end
      w = pending_windows.pop_front();
      if (t !== w.end_time)
        report($sformatf("window_end_time %0d, want %0d", t, w.end_time));
      if (a !== w.activity)
        report($sformatf("window_activity %0d, want %0d (end %0d)", a, w.activity, w.end_time));
      if (p !== w.percent)
        report($sformatf("usage_percent %0d, want %0d (end %0d)", p, w.percent, w.end_time));
    endtask
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     push = 1'b0;
  logic                     full;
  logic [CMD_BITS-1:0]      command = CMD_TICK;
  logic [REQ_BITS-1:0]      new_level = '0;
  logic                     empty;
  logic                     pop = 1'b0;
  logic [OUT_TIME_BITS-1:0] window_end_time;
  logic [ACT_BITS-1:0]      window_activity;
  logic [PCT_BITS-1:0]      usage_percent;
  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = CFG_NUM_LEVELS;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  window_scoreboard sb = new();
  int send_idle_pct = 7;
  int pop_stall_pct = 68;
  int unsigned cycles = 0;

  windowed_usage_level_monitor dut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .command         (command),
    .new_level       (new_level),
    .empty           (empty),
    .pop             (pop),
    .window_end_time (window_end_time),
    .window_activity (window_activity),
    .usage_percent   (usage_percent),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Result side: check each popped transaction, stall at random
  always @(posedge clk) begin
    if (!rst && pop && empty === 1'b0)
      sb.check_window(window_end_time, window_activity, usage_percent);
    pop <= rst ? 1'b0 : ($urandom_range(99) >= pop_stall_pct);
  end

  // Offer one command, with random idle cycles ahead of it
  task automatic send_command(cmd_t c, logic [REQ_BITS-1:0] lv);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    command   <= c;
    new_level <= lv;
    @(posedge clk);
    while (full !== 1'b0) @(posedge clk);
    sb.note_command(c, lv);
  endtask

  // Hold off the sender until every queued window has been popped
  task automatic drain_windows();
    push <= 1'b0;
    do @(posedge clk); while (sb.pending_windows.size() != 0);
  endtask

  // Block idle: nothing queued and the back end given time to finish
  task automatic settle();
    drain_windows();
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_register(idx, data);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int                       r;
    logic [NLEV_BITS-1:0]     nl;
    logic [CFG_DATA_BITS-1:0] nl_data;
    logic [WIN_BITS-1:0]      wc;
    cmd_t                     c;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Full level range: saturation at top and at zero
    write_reg(CFG_NUM_LEVELS, 32'd256);
    write_reg(CFG_WINDOW_CYCLES, 32'd4);
    send_command(CMD_SET, 8'hFF);
    send_command(CMD_TICK, 8'h00);
    send_command(CMD_INC, 8'h5A);
    send_command(CMD_TICK, 8'hA5);
    send_command(CMD_DEC, 8'h00);
    send_command(CMD_TICK, 8'hFF);
    send_command(CMD_SET, 8'h00);
    send_command(CMD_DEC, 8'hFF);
    send_command(CMD_TICK, 8'h00);
    settle();

    // Level count past the cap, zero-length window
    write_reg(CFG_NUM_LEVELS, 32'd511);
    write_reg(CFG_WINDOW_CYCLES, 32'd0);
    send_command(CMD_SET, 8'd200);
    send_command(CMD_TICK, 8'h00);
    send_command(CMD_INC, 8'h00);
    send_command(CMD_TICK, 8'h00);
    settle();

    // One level, then none, while the held level sits above top
    write_reg(CFG_NUM_LEVELS, 32'd1);
    send_command(CMD_TICK, 8'h00);
    send_command(CMD_INC, 8'h00);
    send_command(CMD_TICK, 8'h00);
    send_command(CMD_DEC, 8'h00);
    send_command(CMD_TICK, 8'h00);
    settle();
    write_reg(CFG_NUM_LEVELS, 32'd0);
    send_command(CMD_SET, 8'd77);
    send_command(CMD_TICK, 8'h00);
    settle();

    // Activity above top times window: percent saturates
    write_reg(CFG_NUM_LEVELS, 32'd256);
    send_command(CMD_SET, 8'hFF);
    settle();
    write_reg(CFG_NUM_LEVELS, 32'd10);
    write_reg(CFG_WINDOW_CYCLES, 32'd2);
    send_command(CMD_TICK, 8'h00);
    send_command(CMD_TICK, 8'h00);
    settle();

    // Window shortened while a window is partly counted
    write_reg(CFG_WINDOW_CYCLES, 32'd10);
    send_command(CMD_TICK, 8'h00);
    send_command(CMD_TICK, 8'h00);
    send_command(CMD_TICK, 8'h00);
    settle();
    write_reg(CFG_WINDOW_CYCLES, 32'd2);
    send_command(CMD_TICK, 8'h00);
    settle();

    // Random phases, each under its own configuration and idle pattern
    for (int p = 0; p < PHASES; p++) begin
      if (p < 4) begin
        send_idle_pct = 7;
        pop_stall_pct = 68;
      end else if (p < 8) begin
        send_idle_pct = 68;
        pop_stall_pct = 7;
      end else begin
        send_idle_pct = 0;
        pop_stall_pct = 0;
      end

      case (p % 6)
        0: nl = 9'd2;
        1: nl = 9'd256;
        2: nl = 9'($urandom_range(255, 3));
        3: nl = 9'd511;
        4: nl = 9'($urandom_range(1, 0));
        default: nl = 9'($urandom_range(256, 2));
      endcase
      // Bits above the register width are don't-care
      nl_data = {23'd0, nl};
      if (p % 2 == 1) nl_data = ($urandom() & 32'hFFFF_FE00) | nl_data;

      if (p == 7) wc = 32'hFFFF_FFFF;
      else if (p % 4 == 3) wc = '0;
      else if ($urandom_range(3) == 0) wc = 32'($urandom_range(90, 20));
      else wc = 32'($urandom_range(12, 1));

      settle();
      write_reg(CFG_NUM_LEVELS, nl_data);
      write_reg(CFG_WINDOW_CYCLES, wc);

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2 && p % 3 == 1) drain_windows();
        r = $urandom_range(99);
        if (r < 55) c = CMD_TICK;
        else if (r < 70) c = CMD_INC;
        else if (r < 85) c = CMD_DEC;
        else c = CMD_SET;
        send_command(c, 8'($urandom()));
      end
    end

    // Wind down: all windows out, then watch for stray transactions
    drain_windows();
    repeat (60) @(posedge clk);
    if (sb.pending_windows.size() != 0)
      sb.report($sformatf("%0d windows never came out", sb.pending_windows.size()));
    if (sb.mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
